@@ hw/rtl/d4dwt_pkg.sv @@
package d4dwt_pkg;

  localparam int unsigned MaxLog2Rows = 6;
  localparam int unsigned MaxLog2Cols = 6;
  localparam int unsigned Taps        = 4;
  localparam int unsigned AddrW       = MaxLog2Rows + MaxLog2Cols;
  localparam int unsigned PtrW        = AddrW + 1;
  localparam int unsigned LineW       = (MaxLog2Rows > MaxLog2Cols) ? MaxLog2Rows : MaxLog2Cols;
  localparam int unsigned LineCntW    = LineW + 1;
  localparam int unsigned TapW        = 16;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ProdW       = WordW + TapW;
  localparam int unsigned AccW        = ProdW + 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [CfgIdxW-1:0] CFG_LOG2_ROWS     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOG2_COLS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COARSEST      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOWPASS_TAPS  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HIGHPASS_TAPS = 3'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic             ld_wr;
    logic [AddrW-1:0] ld_addr;
    logic             rd;
    logic [AddrW-1:0] rd_addr;
    logic             fill;
    logic [LineW-1:0] fill_idx;
    logic             mac;
    logic [LineW-1:0] lb_idx;
    logic             hp;
    logic [1:0]       tap;
    logic             first;
    logic             last;
    logic [AddrW-1:0] dst;
    logic             out_load;
    logic             out_last_ch;
    logic             out_last_b;
  } d4dwt_cmd_t;

  function automatic logic [2:0] clamp_log2(input logic [2:0] v, input logic [2:0] hi);
    logic [2:0] r;
    r = v;
    if (v == 3'd0) r = 3'd1;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

@@ hw/rtl/d4dwt_ctrl.sv @@
module d4dwt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  output logic                  in_ready_o,
  input  logic                  out_free_i,
  input  logic [2:0]            log2_rows_i,
  input  logic [2:0]            log2_cols_i,
  input  logic [2:0]            coarsest_i,
  input  logic [4:0]            channel_count_i,
  output d4dwt_pkg::d4dwt_cmd_t cmd_o
);
  import d4dwt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEVEL, ST_FILL, ST_FILL_DR, ST_MAC, ST_MAC_DR, ST_RD_ISSUE, ST_RD_DATA
  } state_e;

  state_e              state_q;
  logic [PtrW-1:0]     lp_q, rp_q;
  logic                tf_q;
  logic [3:0]          ch_q;
  logic [2:0]          lm_q, ln_q, lev_q;
  logic                pass_q;
  logic [LineCntW-1:0] line_q, e_q;
  logic [LineW-1:0]    i_q;
  logic [2:0]          k_q;
  logic [2:0]          drain_q;

  logic [2:0]          jm, jn, len_log, lines_log;
  logic [4:0]          chans;
  logic [PtrW-1:0]     size;
  logic [LineCntW-1:0] len_m1, lines_m1, idx7, two_i, dst_e;
  logic [LineW-1:0]    half_m1;
  logic                accept, last_ch, last_b;

  function automatic logic [AddrW-1:0] addr_of(input logic [LineCntW-1:0] a,
                                              input logic [LineCntW-1:0] b,
                                              input logic [2:0] sh);
    return (AddrW'(a) << sh) | AddrW'(b);
  endfunction

  always_comb begin
    jm        = clamp_log2(log2_rows_i, 3'(MaxLog2Rows));
    jn        = clamp_log2(log2_cols_i, 3'(MaxLog2Cols));
    chans     = (channel_count_i == 5'd0) ? 5'd1 :
                (channel_count_i > 5'd16) ? 5'd16 : channel_count_i;
    size      = PtrW'(1) << (4'(jm) + 4'(jn));
    len_log   = pass_q ? ln_q : lm_q;
    lines_log = pass_q ? lm_q : ln_q;
    len_m1    = LineCntW'((LineCntW'(1) << len_log) - LineCntW'(1));
    lines_m1  = LineCntW'((LineCntW'(1) << lines_log) - LineCntW'(1));
    half_m1   = LineW'(len_m1 >> 1);
    two_i     = {i_q, 1'b0};
    idx7      = k_q[2] ? LineCntW'(two_i + LineCntW'(5) - LineCntW'(k_q))
                       : LineCntW'(two_i + LineCntW'(k_q));
    dst_e     = k_q[2] ? LineCntW'(i_q) + LineCntW'(half_m1) + LineCntW'(1) : LineCntW'(i_q);
    last_ch   = (PtrW'(rp_q + PtrW'(1)) >= size);
    last_b    = last_ch && ((5'(ch_q) + 5'd1) >= chans);
    in_ready_o = (state_q == ST_IDLE);
    accept    = in_ready_o && in_valid_i;

    cmd_o             = '0;
    cmd_o.ld_wr       = accept && (in_cmd_i == CMD_LOAD) && !tf_q && (lp_q < size);
    cmd_o.ld_addr     = lp_q[AddrW-1:0];
    cmd_o.fill_idx    = e_q[LineW-1:0];
    cmd_o.lb_idx      = LineW'(idx7 & len_m1);
    cmd_o.hp          = k_q[2];
    cmd_o.tap         = k_q[1:0];
    cmd_o.first       = (k_q[1:0] == 2'd0);
    cmd_o.last        = (k_q[1:0] == 2'd3);
    cmd_o.out_last_ch = last_ch;
    cmd_o.out_last_b  = last_b;
    cmd_o.rd_addr     = pass_q ? addr_of(e_q, line_q, jm) : addr_of(line_q, e_q, jm);
    cmd_o.dst         = pass_q ? addr_of(dst_e, line_q, jm) : addr_of(line_q, dst_e, jm);
    unique case (state_q)
      ST_FILL: begin
        cmd_o.rd   = 1'b1;
        cmd_o.fill = 1'b1;
      end
      ST_MAC:  cmd_o.mac = 1'b1;
      ST_RD_ISSUE: begin
        cmd_o.rd      = out_free_i;
        cmd_o.rd_addr = rp_q[AddrW-1:0];
      end
      ST_RD_DATA: cmd_o.out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lp_q    <= '0;
      rp_q    <= '0;
      tf_q    <= 1'b0;
      ch_q    <= '0;
      lm_q    <= '0;
      ln_q    <= '0;
      lev_q   <= '0;
      pass_q  <= 1'b0;
      line_q  <= '0;
      e_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.ld_wr) lp_q <= PtrW'(lp_q + PtrW'(1));
          if (accept && in_cmd_i == CMD_READ) begin
            if (tf_q) begin
              state_q <= ST_RD_ISSUE;
            end else begin
              lm_q    <= jm;
              ln_q    <= jn;
              lev_q   <= (jm > jn) ? jm : jn;
              state_q <= ST_LEVEL;
            end
          end
        end
        ST_LEVEL: begin
          line_q <= '0;
          e_q    <= '0;
          if (lev_q > coarsest_i) begin
            pass_q  <= !(lm_q > coarsest_i);
            state_q <= ST_FILL;
          end else begin
            tf_q    <= 1'b1;
            state_q <= ST_RD_ISSUE;
          end
        end
        ST_FILL: begin
          if (e_q == len_m1) begin
            e_q     <= '0;
            state_q <= ST_FILL_DR;
          end else begin
            e_q <= LineCntW'(e_q + LineCntW'(1));
          end
        end
        ST_FILL_DR: begin
          i_q     <= '0;
          k_q     <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          k_q <= 3'(k_q + 3'd1);
          if (k_q == 3'd7) begin
            if (i_q == half_m1) begin
              drain_q <= '0;
              state_q <= ST_MAC_DR;
            end else begin
              i_q <= LineW'(i_q + LineW'(1));
            end
          end
        end
        ST_MAC_DR: begin
          drain_q <= 3'(drain_q + 3'd1);
          if (drain_q == 3'd3) begin
            if (line_q == lines_m1) begin
              line_q <= '0;
              if (!pass_q && ln_q > coarsest_i) begin
                pass_q  <= 1'b1;
                state_q <= ST_FILL;
              end else begin
                if (lm_q > coarsest_i) lm_q <= 3'(lm_q - 3'd1);
                if (ln_q > coarsest_i) ln_q <= 3'(ln_q - 3'd1);
                lev_q   <= 3'(lev_q - 3'd1);
                state_q <= ST_LEVEL;
              end
            end else begin
              line_q  <= LineCntW'(line_q + LineCntW'(1));
              state_q <= ST_FILL;
            end
          end
        end
        ST_RD_ISSUE: begin
          if (out_free_i) state_q <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          state_q <= ST_IDLE;
          if (last_ch) begin
            rp_q <= '0;
            lp_q <= '0;
            tf_q <= 1'b0;
            ch_q <= last_b ? 4'd0 : 4'(ch_q + 4'd1);
          end else begin
            rp_q <= PtrW'(rp_q + PtrW'(1));
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/d4dwt_dpath.sv @@
module d4dwt_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  d4dwt_pkg::d4dwt_cmd_t                cmd_i,
  input  logic signed [15:0]                   sample_re_i,
  input  logic signed [15:0]                   sample_im_i,
  input  logic [d4dwt_pkg::CfgDataW-1:0]       lowpass_taps_i,
  input  logic [d4dwt_pkg::CfgDataW-1:0]       highpass_taps_i,
  output logic signed [d4dwt_pkg::WordW-1:0]   rdata_re_o,
  output logic signed [d4dwt_pkg::WordW-1:0]   rdata_im_o
);
  import d4dwt_pkg::*;

  localparam int unsigned StoreDepth = 1 << AddrW;
  localparam int unsigned LineDepth  = 1 << LineW;
  localparam int unsigned ShW        = AccW + 1 - 14;

  typedef struct packed {
    logic             hp;
    logic [1:0]       tap;
    logic             first;
    logic             last;
    logic [AddrW-1:0] dst;
  } tag_t;

  logic signed [WordW-1:0] store_re [StoreDepth];
  logic signed [WordW-1:0] store_im [StoreDepth];
  logic signed [WordW-1:0] lb_re [LineDepth];
  logic signed [WordW-1:0] lb_im [LineDepth];

  logic signed [WordW-1:0] rdata_re_q, rdata_im_q, lbd_re_q, lbd_im_q;
  logic                    fill_q, s1_v_q, s2_v_q, wb_v_q;
  logic [LineW-1:0]        fill_idx_q;
  tag_t                    s1_q, s2_q;
  logic signed [ProdW-1:0] prod_re_q, prod_im_q;
  logic signed [AccW-1:0]  acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic [AddrW-1:0]        wb_addr_q;
  logic signed [TapW-1:0]  tap;
  logic signed [WordW-1:0] wb_re, wb_im;

  function automatic logic signed [WordW-1:0] requant(input logic signed [AccW-1:0] s);
    logic signed [AccW:0]  t;
    logic signed [ShW-1:0] q;
    logic signed [WordW-1:0] r;
    t = (AccW+1)'(s) + (AccW+1)'(8192);
    q = ShW'(t >>> 14);
    if (q[ShW-1:WordW-1] == {(ShW-WordW+1){q[ShW-1]}}) r = q[WordW-1:0];
    else if (q[ShW-1]) r = 32'sh80000000;
    else r = 32'sh7fffffff;
    return r;
  endfunction

  always_comb begin
    tap      = s1_q.hp ? highpass_taps_i[16*s1_q.tap +: TapW]
                       : lowpass_taps_i[16*s1_q.tap +: TapW];
    acc_re_d = s2_q.first ? AccW'(prod_re_q) : AccW'(acc_re_q + AccW'(prod_re_q));
    acc_im_d = s2_q.first ? AccW'(prod_im_q) : AccW'(acc_im_q + AccW'(prod_im_q));
    wb_re    = requant(acc_re_q);
    wb_im    = requant(acc_im_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      store_re[cmd_i.ld_addr] <= WordW'(sample_re_i);
      store_im[cmd_i.ld_addr] <= WordW'(sample_im_i);
    end else if (wb_v_q) begin
      store_re[wb_addr_q] <= wb_re;
      store_im[wb_addr_q] <= wb_im;
    end
    if (cmd_i.rd) begin
      rdata_re_q <= store_re[cmd_i.rd_addr];
      rdata_im_q <= store_im[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_q) begin
      lb_re[fill_idx_q] <= rdata_re_q;
      lb_im[fill_idx_q] <= rdata_im_q;
    end
    if (cmd_i.mac) begin
      lbd_re_q <= lb_re[cmd_i.lb_idx];
      lbd_im_q <= lb_im[cmd_i.lb_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    fill_idx_q <= cmd_i.fill_idx;
    s1_q       <= '{hp: cmd_i.hp, tap: cmd_i.tap, first: cmd_i.first,
                    last: cmd_i.last, dst: cmd_i.dst};
    s2_q       <= s1_q;
    prod_re_q  <= lbd_re_q * tap;
    prod_im_q  <= lbd_im_q * tap;
    if (s2_v_q) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
    wb_addr_q  <= s2_q.dst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      wb_v_q <= 1'b0;
    end else begin
      fill_q <= cmd_i.fill;
      s1_v_q <= cmd_i.mac;
      s2_v_q <= s1_v_q;
      wb_v_q <= s2_v_q && s2_q.last;
    end
  end

  assign rdata_re_o = rdata_re_q;
  assign rdata_im_o = rdata_im_q;

endmodule

@@ hw/rtl/daub4_forward_2d_wavelet.sv @@
// Two-dimensional periodic four-tap wavelet analysis of complex frames.
// Requests arrive on the slave stream: tuser selects load (0) or read (1),
// tdata carries the sample. Loads fill the current frame column-major, one
// request per cycle while no read is running. The first read of a frame runs the full
// multi-level transform in place, then each read returns one coefficient on
// the master stream with tlast on the last coefficient of the frame and tuser
// on the last coefficient of the batch.
// A read of an already transformed frame passes through the store read
// register into the output register before the next request is taken, so
// reads do not overlap. The transform uses the single multiply-accumulate
// unit per plane: each line of length n is read from the store into the line
// buffer, then runs eight taps per output pair and drains the pipeline, over
// all column and row lines of every level.
// Configuration must be written through the plain write port only while the
// block is idle; the block itself does not enforce this. Reset clears the
// pointers, the channel index and the output valid flag; the frame store is
// undefined until loaded. When the receiver holds tready low, the result
// stays in the output register and the next read waits.
module daub4_forward_2d_wavelet (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [d4dwt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [d4dwt_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [31:0]                         s_axis_tdata_i,  // sample_re, sample_im
  input  logic                                s_axis_tuser_i,  // cmd
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [63:0]                         m_axis_tdata_o,  // coeff_re, coeff_im
  output logic                                m_axis_tlast_o,  // last_of_channel
  output logic                                m_axis_tuser_o   // last_of_batch
);
  import d4dwt_pkg::*;

  logic [2:0]          log2_rows_q, log2_cols_q, coarsest_q;
  logic [4:0]          channel_count_q;
  logic [CfgDataW-1:0] lowpass_q, highpass_q;
  logic                out_valid_q, out_last_q, out_user_q;
  logic [63:0]         out_data_q;
  logic signed [WordW-1:0] rdata_re, rdata_im;
  d4dwt_cmd_t          cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_rows_q     <= 3'd6;
      log2_cols_q     <= 3'd6;
      coarsest_q      <= 3'd0;
      channel_count_q <= 5'd1;
      lowpass_q       <= '0;
      highpass_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOG2_ROWS:     log2_rows_q     <= cfg_data_i[2:0];
        CFG_LOG2_COLS:     log2_cols_q     <= cfg_data_i[2:0];
        CFG_COARSEST:      coarsest_q      <= cfg_data_i[2:0];
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[4:0];
        CFG_LOWPASS_TAPS:  lowpass_q       <= cfg_data_i;
        CFG_HIGHPASS_TAPS: highpass_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  d4dwt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_cmd_i        (s_axis_tuser_i),
    .in_ready_o      (s_axis_tready_o),
    .out_free_i      (!out_valid_q || m_axis_tready_i),
    .log2_rows_i     (log2_rows_q),
    .log2_cols_i     (log2_cols_q),
    .coarsest_i      (coarsest_q),
    .channel_count_i (channel_count_q),
    .cmd_o           (cmd)
  );

  d4dwt_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_re_i     (s_axis_tdata_i[15:0]),
    .sample_im_i     (s_axis_tdata_i[31:16]),
    .lowpass_taps_i  (lowpass_q),
    .highpass_taps_i (highpass_q),
    .rdata_re_o      (rdata_re),
    .rdata_im_o      (rdata_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= {rdata_im, rdata_re};
      out_last_q <= cmd.out_last_ch;
      out_user_q <= cmd.out_last_b;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
